[sv/cfdu_pkg.sv]
// Shared types and constants for the checksummed frame deframer.
// Depends on nothing; used by cfdu_core and checksummed_frame_deframer_unit.
`default_nettype none

package cfdu_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

    // Which field of the frame is expected next.
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAY  = 3'd3,
        PH_SUM  = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] frame_command;
        t_kind             kind;
    } t_result;

endpackage

`default_nettype wire

[sv/cfdu_core.sv]
// Frame state and the per-beat parse step of the deframer.
// Depends on cfdu_pkg for the phase, kind and result types.
`default_nettype none

module cfdu_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [cfdu_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [cfdu_pkg::BYTE_W-1:0] i_header,
    output logic                           o_emit,
    output cfdu_pkg::t_result              o_result
);

    cfdu_pkg::t_phase           r_phase, n_phase;
    logic [cfdu_pkg::BYTE_W-1:0] r_cmd, n_cmd;
    logic [cfdu_pkg::BYTE_W-1:0] r_len, n_len;
    logic [cfdu_pkg::BYTE_W-1:0] r_seen, n_seen;
    logic [cfdu_pkg::BYTE_W-1:0] r_sum, n_sum;
    logic [cfdu_pkg::BYTE_W-1:0] w_sum_add;
    logic [cfdu_pkg::BYTE_W-1:0] w_seen_inc;

    assign w_sum_add  = r_sum + i_byte;
    assign w_seen_inc = r_seen + 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_seen   = r_seen;
        n_sum    = r_sum;
        o_emit   = 1'b0;
        o_result.kind          = cfdu_pkg::KIND_PAYLOAD;
        o_result.frame_command = r_cmd;
        o_result.frame_length  = r_len;
        o_result.payload_byte  = '0;
        o_result.payload_index = '0;
        case (r_phase)
            cfdu_pkg::PH_HUNT: begin
                if (i_byte == i_header) begin
                    n_sum   = i_byte;
                    n_phase = cfdu_pkg::PH_CMD;
                end
            end
            cfdu_pkg::PH_CMD: begin
                n_cmd   = i_byte;
                n_sum   = w_sum_add;
                n_phase = cfdu_pkg::PH_LEN;
            end
            cfdu_pkg::PH_LEN: begin
                n_len   = i_byte;
                n_sum   = w_sum_add;
                n_seen  = '0;
                n_phase = (i_byte == '0) ? cfdu_pkg::PH_SUM : cfdu_pkg::PH_PAY;
            end
            cfdu_pkg::PH_PAY: begin
                n_sum  = w_sum_add;
                n_seen = w_seen_inc;
                if (w_seen_inc == r_len) begin
                    n_phase = cfdu_pkg::PH_SUM;
                end
                o_emit = 1'b1;
                o_result.payload_byte  = i_byte;
                o_result.payload_index = r_seen;
            end
            cfdu_pkg::PH_SUM: begin
                o_emit  = 1'b1;
                n_phase = cfdu_pkg::PH_HUNT;
                n_cmd   = '0;
                n_len   = '0;
                n_seen  = '0;
                n_sum   = '0;
                if (i_byte == r_sum) begin
                    o_result.kind = cfdu_pkg::KIND_GOOD;
                end else begin
                    o_result.kind = cfdu_pkg::KIND_BAD;
                    // A failed checksum byte that matches the header opens a new frame.
                    if (i_byte == i_header) begin
                        n_sum   = i_byte;
                        n_phase = cfdu_pkg::PH_CMD;
                    end
                end
            end
            default: begin
                n_phase = cfdu_pkg::PH_HUNT;
                n_cmd   = '0;
                n_len   = '0;
                n_seen  = '0;
                n_sum   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cfdu_pkg::PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

`ifndef SYNTHESIS
    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cfdu_pkg::PH_HUNT |-> !o_emit)
        else $error("cfdu_core: result raised while hunting for a header");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == cfdu_pkg::PH_LEN && i_byte == '0
        |=> r_phase == cfdu_pkg::PH_SUM)
        else $error("cfdu_core: zero length frame did not go to checksum");

    a_end_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && o_result.kind != cfdu_pkg::KIND_PAYLOAD |-> r_phase == cfdu_pkg::PH_SUM)
        else $error("cfdu_core: end of frame reported outside the checksum phase");
`endif

endmodule

`default_nettype wire

[sv/checksummed_frame_deframer_unit.sv]
// Top level of the checksummed frame deframer: stream ports, config register,
// input and result registers. Depends on cfdu_pkg and cfdu_core.
`default_nettype none

// The deframer takes one received byte per input beat and searches for the
// header byte (the configuration register, 0xAA after reset). A frame is the
// header, a command byte, a length byte, that many payload bytes and a checksum
// byte equal to the 8-bit wrapping sum of header, command, length and payload.
// Payload bytes are forwarded cut-through as they arrive, tagged with the frame's
// command, length and byte index; the checksum byte yields one end beat that
// says good or bad, and the consumer drops the bytes of a bad frame. Header,
// command and length bytes make no output beat, nor do bytes outside a frame.
// A bad checksum byte that equals the header starts the next frame right away.
// Each byte passes through an input register, combinational parse logic and a
// result register; a byte waits in the input register until the result
// register is free or drains, and its result beat is then offered from the
// result register. One byte is taken every cycle as long as the result register
// is empty or being drained; a stalled consumer holds both registers. The header
// register may be written only while the block is idle.
module checksummed_frame_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: header byte.
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    // Received bytes. tdata: [7:0] rx_byte.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,
    // Results. tdata: [7:0] frame_command, [15:8] frame_length,
    // [23:16] payload_byte, [31:24] payload_index. tuser: [1:0] kind.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,
    output logic [1:0]       o_m_tuser
);

    logic [cfdu_pkg::BYTE_W-1:0] r_header;
    logic                        r_in_valid;
    logic [cfdu_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_out_valid;
    cfdu_pkg::t_result           r_out;
    logic                        w_advance;
    logic                        w_emit;
    cfdu_pkg::t_result           w_result;

    // The held byte moves on when the result register is free or drains now.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= cfdu_pkg::HEADER_RESET;
        end else if (i_cfg_we) begin
            r_header <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    cfdu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_header (r_header),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.payload_index, r_out.payload_byte,
                         r_out.frame_length, r_out.frame_command};
    assign o_m_tuser  = r_out.kind;

`ifndef SYNTHESIS
    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_in_valid)
        else $error("deframer: accepted byte was not captured");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte))
        else $error("deframer: waiting byte was lost or changed");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != cfdu_pkg::KIND_PAYLOAD
        |-> r_out.payload_byte == '0 && r_out.payload_index == '0)
        else $error("deframer: end beat carries payload data");
`endif

endmodule

`default_nettype wire
